// ===== rtl/lca_pkg.sv =====
// lca_pkg: sizes, field types, operation codes and sequencer states of the
// lru channel allocator. No dependencies; every other file imports it.

package lca_pkg;

    localparam int CLIENT_SLOTS = 256;
    localparam int CHANNELS     = 6;
    localparam int STAMP_BITS   = 32;
    localparam int TAG_BITS     = 16;

    localparam int ROW_BITS = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int CH_BITS  = $clog2(CHANNELS);

    // fixed request and response field widths
    localparam int FUNC_BITS   = 3;
    localparam int CLIENT_BITS = 8;
    localparam int OBJECT_BITS = 16;
    localparam int CHF_BITS    = 3;
    localparam int TICK_BITS   = 32;

    typedef logic [FUNC_BITS-1:0]   func_t;
    typedef logic [CLIENT_BITS-1:0] client_t;
    typedef logic [OBJECT_BITS-1:0] object_t;
    typedef logic [CHF_BITS-1:0]    chan_field_t;
    typedef logic [TICK_BITS-1:0]   ticks_t;

    localparam func_t FUNC_ANON_AUTO    = 3'd0;
    localparam func_t FUNC_OWNED_AUTO   = 3'd1;
    localparam func_t FUNC_TRY_REUSE    = 3'd2;
    localparam func_t FUNC_MANUAL       = 3'd3;
    localparam func_t FUNC_RESET_CLIENT = 3'd4;

    typedef logic [ROW_BITS-1:0]   row_idx_t;
    typedef logic [CH_BITS-1:0]    ch_idx_t;
    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [TAG_BITS-1:0]   tag_t;

    typedef struct packed {
        stamp_t stamp;
        tag_t   tag;
    } chan_entry_t;

    typedef chan_entry_t [CHANNELS-1:0] row_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH
    } lca_state_t;

    // control from the sequencer to the row store
    typedef struct packed {
        logic     rd_en;
        logic     wr_en;
        logic     clr_en;
        row_idx_t row;
    } lca_store_cmd_t;

endpackage

// ===== rtl/lca_req_if.sv =====
// lca_req_if: request channel of the lru channel allocator
// depends on lca_pkg for the field types

interface lca_req_if
    import lca_pkg::*;
;
    logic        valid;
    logic        ready;
    func_t       func;
    client_t     client;
    object_t     object_id;
    chan_field_t hint_channel;
    chan_field_t manual_channel;
    ticks_t      now_ticks;

    modport source (
        output valid, func, client, object_id, hint_channel, manual_channel, now_ticks,
        input  ready
    );

    modport sink (
        input  valid, func, client, object_id, hint_channel, manual_channel, now_ticks,
        output ready
    );
endinterface

// ===== rtl/lca_rsp_if.sv =====
// lca_rsp_if: response channel of the lru channel allocator
// depends on lca_pkg for the field types

interface lca_rsp_if
    import lca_pkg::*;
;
    logic        valid;
    logic        ready;
    chan_field_t channel;
    logic        found;
    logic        reused;

    modport source (
        output valid, channel, found, reused,
        input  ready
    );

    modport sink (
        input  valid, channel, found, reused,
        output ready
    );
endinterface

// ===== rtl/lca_row_store.sv =====
// lca_row_store: one row of channel stamps and owner tags per client, with a
// registered read port and a valid bit per row so unwritten rows read as zero
// depends on lca_pkg

module lca_row_store
    import lca_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  lca_store_cmd_t cmd,
    input  row_t           wr_data,
    output row_t           rd_data
);

    row_t                    mem [CLIENT_SLOTS];
    row_t                    rd_data_reg;
    logic                    rd_valid_reg;
    logic [CLIENT_SLOTS-1:0] row_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.row] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                row_valid_reg[cmd.row] <= 1'b1;
            end
            else if (cmd.clr_en)
            begin
                row_valid_reg[cmd.row] <= 1'b0;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[cmd.row];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/lca_if_note_placeholder.sv =====
// lca_owner_check: ownership test of a request's hint channel against the
// owner tag held in the client row
// depends on lca_pkg

module lca_owner_check
    import lca_pkg::*;
(
    input  row_t        row_data,
    input  tag_t        tag,
    input  chan_field_t hint,
    output logic        owns
);

    logic    hint_ok;
    ch_idx_t hint_idx;
    tag_t    hint_tag;

    always_comb
    begin
        hint_ok  = (32'(hint) < CHANNELS);
        hint_idx = CH_BITS'(hint);
        hint_tag = hint_ok ? row_data[hint_idx].tag : '0;
        owns     = hint_ok && (tag != '0) && (hint_tag == tag);
    end

endmodule

// ===== rtl/lru_channel_allocator.sv =====
// Least recently used display channel allocator with owner tags. A request
// that selects a channel is read-modify-write on one client row: the row is
// read, a single stamp comparator walks the channels one per cycle to find the
// least recently used one (lowest index on ties), and the updated row is
// written back. Reset client clears the row's valid bit; unknown operations
// and out-of-range clients leave the store untouched. req.ready is high only
// while no request is in progress; the response sits in an output register,
// so a new request may be taken while it waits. Rows carry valid bits cleared
// at reset, so the store needs no clearing pass.
// depends on lca_pkg, lca_req_if, lca_rsp_if, lca_row_store, lca_owner_check

module lru_channel_allocator
    import lca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lca_req_if.sink   req,
    lca_rsp_if.source rsp
);

    lca_state_t state_reg, state_next;

    func_t       func_reg, func_next;
    row_idx_t    row_reg, row_next;
    tag_t        tag_reg, tag_next;
    chan_field_t hint_reg, hint_next;
    chan_field_t manual_reg, manual_next;
    stamp_t      now_reg, now_next;
    ch_idx_t     idx_reg, idx_next;
    ch_idx_t     best_reg, best_next;
    stamp_t      best_stamp_reg, best_stamp_next;
    ch_idx_t     ch_reg, ch_next;
    tag_t        new_tag_reg, new_tag_next;
    logic        do_write_reg, do_write_next;
    logic        found_reg, found_next;
    logic        reused_reg, reused_next;

    logic        out_valid_reg, out_valid_next;
    chan_field_t out_channel_reg, out_channel_next;
    logic        out_found_reg, out_found_next;
    logic        out_reused_reg, out_reused_next;

    lca_store_cmd_t store_cmd;
    row_t           row_data;
    row_t           wr_row;
    logic           owns;
    logic           accept;
    logic           client_ok;
    logic           manual_ok;
    logic           out_free;
    logic           stamp_less;
    stamp_t         scan_stamp;

    lca_row_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (store_cmd),
        .wr_data (wr_row),
        .rd_data (row_data)
    );

    lca_owner_check u_owner (
        .row_data (row_data),
        .tag      (tag_reg),
        .hint     (hint_reg),
        .owns     (owns)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        wr_row                = row_data;
        wr_row[ch_reg].stamp  = now_reg;
        wr_row[ch_reg].tag    = new_tag_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        row_next         = row_reg;
        tag_next         = tag_reg;
        hint_next        = hint_reg;
        manual_next      = manual_reg;
        now_next         = now_reg;
        idx_next         = idx_reg;
        best_next        = best_reg;
        best_stamp_next  = best_stamp_reg;
        ch_next          = ch_reg;
        new_tag_next     = new_tag_reg;
        do_write_next    = do_write_reg;
        found_next       = found_reg;
        reused_next      = reused_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_channel_next = out_channel_reg;
        out_found_next   = out_found_reg;
        out_reused_next  = out_reused_reg;

        store_cmd.rd_en  = 1'b0;
        store_cmd.wr_en  = 1'b0;
        store_cmd.clr_en = 1'b0;
        store_cmd.row    = row_reg;

        client_ok  = (32'(req.client) < CLIENT_SLOTS);
        manual_ok  = (32'(manual_reg) < CHANNELS);
        scan_stamp = row_data[idx_reg].stamp;
        stamp_less = (scan_stamp < best_stamp_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                store_cmd.row = ROW_BITS'(req.client);
                if (accept)
                begin
                    func_next     = req.func;
                    row_next      = ROW_BITS'(req.client);
                    tag_next      = TAG_BITS'(req.object_id);
                    hint_next     = req.hint_channel;
                    manual_next   = req.manual_channel;
                    now_next      = STAMP_BITS'(req.now_ticks);
                    ch_next       = '0;
                    do_write_next = 1'b0;
                    found_next    = 1'b0;
                    reused_next   = 1'b0;
                    if (!client_ok || (req.func > FUNC_RESET_CLIENT))
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (req.func == FUNC_RESET_CLIENT)
                    begin
                        store_cmd.clr_en = 1'b1;
                        state_next       = ST_FINISH;
                    end
                    else
                    begin
                        store_cmd.rd_en = 1'b1;
                        state_next      = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                // default: begin the lru walk at channel 1
                idx_next        = CH_BITS'(1);
                best_next       = '0;
                best_stamp_next = row_data[0].stamp;
                new_tag_next    = '0;
                state_next      = ST_FINISH;
                unique case (func_reg)
                    FUNC_ANON_AUTO:
                    begin
                        state_next = ST_SCAN;
                    end
                    FUNC_OWNED_AUTO:
                    begin
                        new_tag_next = tag_reg;
                        if (owns)
                        begin
                            ch_next       = CH_BITS'(hint_reg);
                            do_write_next = 1'b1;
                            found_next    = 1'b1;
                            reused_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    FUNC_TRY_REUSE:
                    begin
                        new_tag_next = tag_reg;
                        if (owns)
                        begin
                            ch_next       = CH_BITS'(hint_reg);
                            do_write_next = 1'b1;
                            found_next    = 1'b1;
                            reused_next   = 1'b1;
                        end
                    end
                    FUNC_MANUAL:
                    begin
                        if (manual_ok)
                        begin
                            ch_next       = CH_BITS'(manual_reg);
                            do_write_next = 1'b1;
                            found_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (stamp_less)
                begin
                    best_next       = idx_reg;
                    best_stamp_next = scan_stamp;
                end
                if (idx_reg == CH_BITS'(CHANNELS - 1))
                begin
                    ch_next       = stamp_less ? idx_reg : best_reg;
                    do_write_next = 1'b1;
                    found_next    = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + CH_BITS'(1);
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    store_cmd.wr_en  = do_write_reg;
                    out_valid_next   = 1'b1;
                    out_channel_next = CHF_BITS'(ch_reg);
                    out_found_next   = found_reg;
                    out_reused_next  = reused_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        row_reg         <= row_next;
        tag_reg         <= tag_next;
        hint_reg        <= hint_next;
        manual_reg      <= manual_next;
        now_reg         <= now_next;
        idx_reg         <= idx_next;
        best_reg        <= best_next;
        best_stamp_reg  <= best_stamp_next;
        ch_reg          <= ch_next;
        new_tag_reg     <= new_tag_next;
        do_write_reg    <= do_write_next;
        found_reg       <= found_next;
        reused_reg      <= reused_next;
        out_channel_reg <= out_channel_next;
        out_found_reg   <= out_found_next;
        out_reused_reg  <= out_reused_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.channel = out_channel_reg;
    assign rsp.found   = out_found_reg;
    assign rsp.reused  = out_reused_reg;

`ifndef SYNTHESIS
    a_miss_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.channel == '0))
        else $error("response without a channel carries a nonzero channel");

    a_reuse_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.reused) |-> rsp.found)
        else $error("reused flagged without a channel");

    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        store_cmd.wr_en |-> !accept)
        else $error("row write back overlaps a new request");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (32'(idx_reg) < CHANNELS))
        else $error("lru walk index past last channel");
`endif

endmodule
